// ----- sv/sparse_polynomial_adder_defines.svh -----
// Assertion macros shared by the sparse polynomial adder RTL.
`ifndef SPARSE_POLYNOMIAL_ADDER_DEFINES_SVH
`define SPARSE_POLYNOMIAL_ADDER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SPA_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/spa_pkg.sv -----
// Shared types and constants of the sparse polynomial adder.
package spa_pkg;

  localparam int unsigned COEF_W = 16;
  localparam int unsigned EXP_W  = 8;
  localparam int unsigned TERM_W = COEF_W + EXP_W;
  localparam int unsigned SUM_W  = COEF_W + 1;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_ADD    = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ORDER = 2'd2
  } status_e;

  typedef enum logic {
    OP_ACK = 1'b0,
    OP_ADD = 1'b1
  } op_e;

  // One job handed from the front end to the back end.
  typedef struct packed {
    op_e     op;
    status_e status;
  } spa_job_t;

endpackage

// ----- sv/spa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module spa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/spa_fifo.sv -----
// Small job queue between the front end and the back end.
module spa_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- sv/spa_front.sv -----
// Front end: accepts transactions, checks and writes loads, queues jobs.
module spa_front import spa_pkg::*; #(
  parameter int unsigned MAX_TERMS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     cmd_i,
  input  logic signed [COEF_W-1:0]       coef_i,
  input  logic [EXP_W-1:0]               exponent_i,
  output logic                           q_push_o,
  output spa_job_t                       q_job_o,
  input  logic                           q_full_i,
  output logic                           we_a_o,
  output logic                           we_b_o,
  output logic [$clog2(MAX_TERMS)-1:0]   waddr_o,
  output logic [TERM_W-1:0]              wdata_o,
  output logic [$clog2(MAX_TERMS+1)-1:0] cnt_a_o,
  output logic [$clog2(MAX_TERMS+1)-1:0] cnt_b_o,
  input  logic                           add_done_i
);

  localparam int unsigned AW = $clog2(MAX_TERMS);
  localparam int unsigned CW = $clog2(MAX_TERMS + 1);

  logic             busy_q, busy_d;
  logic [CW-1:0]    cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic             pv_a_q, pv_a_d, pv_b_q, pv_b_d;
  logic [EXP_W-1:0] pe_a_q, pe_b_q;

  logic             accept;
  logic             sel_b;
  logic [CW-1:0]    cnt_sel;
  logic             pv_sel;
  logic [EXP_W-1:0] pe_sel;
  logic             do_write;
  status_e          load_status;

  // Stalled while the job queue is full, and busy from an accepted add until the back end finishes the merge.
  assign in_stall_o = busy_q || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign sel_b   = (cmd_i == CMD_LOAD_B);
  assign cnt_sel = sel_b ? cnt_b_q : cnt_a_q;
  assign pv_sel  = sel_b ? pv_b_q : pv_a_q;
  assign pe_sel  = sel_b ? pe_b_q : pe_a_q;

  // Zero terms drop with status ok; full check ranks ahead of the order check.
  always_comb begin
    do_write    = 1'b0;
    load_status = ST_OK;
    if (coef_i == '0) begin
      load_status = ST_OK;
    end else if (cnt_sel == CW'(MAX_TERMS)) begin
      load_status = ST_FULL;
    end else if (pv_sel && (exponent_i >= pe_sel)) begin
      load_status = ST_ORDER;
    end else begin
      do_write = 1'b1;
    end
  end

  always_comb begin
    q_push_o       = 1'b0;
    q_job_o.op     = OP_ACK;
    q_job_o.status = load_status;
    we_a_o         = 1'b0;
    we_b_o         = 1'b0;
    busy_d         = busy_q;
    cnt_a_d        = cnt_a_q;
    cnt_b_d        = cnt_b_q;
    pv_a_d         = pv_a_q;
    pv_b_d         = pv_b_q;
    if (add_done_i) begin
      busy_d  = 1'b0;
      cnt_a_d = '0;
      cnt_b_d = '0;
      pv_a_d  = 1'b0;
      pv_b_d  = 1'b0;
    end
    if (accept) begin
      if (cmd_i inside {CMD_LOAD_A, CMD_LOAD_B}) begin
        q_push_o = 1'b1;
        if (do_write) begin
          if (sel_b) begin
            we_b_o  = 1'b1;
            cnt_b_d = cnt_b_q + 1'b1;
            pv_b_d  = 1'b1;
          end else begin
            we_a_o  = 1'b1;
            cnt_a_d = cnt_a_q + 1'b1;
            pv_a_d  = 1'b1;
          end
        end
      end else begin
        case (cmd_i)
          CMD_ADD: begin
            q_push_o       = 1'b1;
            q_job_o.op     = OP_ADD;
            q_job_o.status = ST_OK;
            busy_d         = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  assign waddr_o = cnt_sel[AW-1:0];
  assign wdata_o = {coef_i, exponent_i};
  assign cnt_a_o = cnt_a_q;
  assign cnt_b_o = cnt_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      pv_a_q  <= 1'b0;
      pv_b_q  <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      pv_a_q  <= pv_a_d;
      pv_b_q  <= pv_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_a_o) begin
      pe_a_q <= exponent_i;
    end
    if (we_b_o) begin
      pe_b_q <= exponent_i;
    end
  end

endmodule

// ----- sv/spa_back.sv -----
// Back end: emits load acks and runs the merge walk over both term stores.
module spa_back import spa_pkg::*; #(
  parameter int unsigned MAX_TERMS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  input  spa_job_t                       q_job_i,
  output logic                           q_pop_o,
  input  logic [$clog2(MAX_TERMS+1)-1:0] cnt_a_i,
  input  logic [$clog2(MAX_TERMS+1)-1:0] cnt_b_i,
  output logic                           rd_en_o,
  output logic [$clog2(MAX_TERMS)-1:0]   raddr_a_o,
  output logic [$clog2(MAX_TERMS)-1:0]   raddr_b_o,
  input  logic [TERM_W-1:0]              rdata_a_i,
  input  logic [TERM_W-1:0]              rdata_b_i,
  output logic                           add_done_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SUM_W-1:0]        sum_coef_o,
  output logic [EXP_W-1:0]               sum_exp_o,
  output logic                           is_last_o,
  output logic                           no_terms_o,
  output logic [1:0]                     status_o
);

  localparam int unsigned AW = $clog2(MAX_TERMS);
  localparam int unsigned CW = $clog2(MAX_TERMS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_MERGE = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [CW-1:0]           i_q, i_d, j_q, j_d;
  logic                    pend_v_q, pend_v_d;
  logic signed [SUM_W-1:0] pend_coef_q, pend_coef_d;
  logic [EXP_W-1:0]        pend_exp_q, pend_exp_d;

  logic                    out_valid_q, out_valid_d;
  logic signed [SUM_W-1:0] out_coef_q, out_coef_d;
  logic [EXP_W-1:0]        out_exp_q, out_exp_d;
  logic                    out_last_q, out_last_d;
  logic                    out_none_q, out_none_d;
  status_e                 out_status_q, out_status_d;
  logic                    load_out;

  logic                    av, bv, out_free;
  logic signed [COEF_W-1:0] ca, cb;
  logic [EXP_W-1:0]        ea, eb;
  logic                    take_a, take_b;
  logic signed [SUM_W-1:0] m_coef;
  logic [EXP_W-1:0]        m_exp;

  assign av = (i_q < cnt_a_i);
  assign bv = (j_q < cnt_b_i);
  assign ca = rdata_a_i[TERM_W-1 -: COEF_W];
  assign cb = rdata_b_i[TERM_W-1 -: COEF_W];
  assign ea = rdata_a_i[EXP_W-1:0];
  assign eb = rdata_b_i[EXP_W-1:0];

  // Output slot can take a new result this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  // One merge step on the two head terms.
  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    m_coef = SUM_W'(cb);
    m_exp  = eb;
    if (av && bv && (ea == eb)) begin
      take_a = 1'b1;
      take_b = 1'b1;
      m_coef = SUM_W'(ca) + SUM_W'(cb);
      m_exp  = ea;
    end else if (!bv || (av && (ea > eb))) begin
      take_a = 1'b1;
      m_coef = SUM_W'(ca);
      m_exp  = ea;
    end else begin
      take_b = 1'b1;
    end
  end

  assign raddr_a_o = av ? i_q[AW-1:0] : '0;
  assign raddr_b_o = bv ? j_q[AW-1:0] : '0;

  // A nonzero term is held back one step so the final one can carry is_last.
  always_comb begin
    state_d      = state_q;
    i_d          = i_q;
    j_d          = j_q;
    pend_v_d     = pend_v_q;
    pend_coef_d  = pend_coef_q;
    pend_exp_d   = pend_exp_q;
    q_pop_o      = 1'b0;
    rd_en_o      = 1'b0;
    add_done_o   = 1'b0;
    load_out     = 1'b0;
    out_coef_d   = '0;
    out_exp_d    = '0;
    out_last_d   = 1'b0;
    out_none_d   = 1'b0;
    out_status_d = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (!q_empty_i && out_free) begin
          q_pop_o = 1'b1;
          if (q_job_i.op == OP_ADD) begin
            i_d      = '0;
            j_d      = '0;
            pend_v_d = 1'b0;
            state_d  = S_READ;
          end else begin
            load_out     = 1'b1;
            out_last_d   = 1'b1;
            out_status_d = q_job_i.status;
          end
        end
      end
      S_READ: begin
        if (av || bv) begin
          rd_en_o = 1'b1;
          state_d = S_MERGE;
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_MERGE: begin
        if (m_coef == '0) begin
          i_d     = i_q + CW'(take_a);
          j_d     = j_q + CW'(take_b);
          state_d = S_READ;
        end else if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            load_out   = 1'b1;
            out_coef_d = pend_coef_q;
            out_exp_d  = pend_exp_q;
          end
          pend_v_d    = 1'b1;
          pend_coef_d = m_coef;
          pend_exp_d  = m_exp;
          i_d         = i_q + CW'(take_a);
          j_d         = j_q + CW'(take_b);
          state_d     = S_READ;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_last_d = 1'b1;
          if (pend_v_q) begin
            out_coef_d = pend_coef_q;
            out_exp_d  = pend_exp_q;
          end else begin
            out_none_d = 1'b1;
          end
          add_done_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pend_v_q    <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pend_v_q    <= pend_v_d;
      i_q         <= i_d;
      j_q         <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_coef_q <= pend_coef_d;
    pend_exp_q  <= pend_exp_d;
    if (load_out) begin
      out_coef_q   <= out_coef_d;
      out_exp_q    <= out_exp_d;
      out_last_q   <= out_last_d;
      out_none_q   <= out_none_d;
      out_status_q <= out_status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sum_coef_o  = out_coef_q;
  assign sum_exp_o   = out_exp_q;
  assign is_last_o   = out_last_q;
  assign no_terms_o  = out_none_q;
  assign status_o    = out_status_q;

endmodule

// ----- sv/sparse_polynomial_adder.sv -----
// Sparse polynomial adder: two term stores, load checks and a merge-by-exponent add.
//
// Loads (cmd 0 into the first store, cmd 1 into the second) are taken one per
// cycle while in_stall_o is low, and each returns one acknowledge transaction
// carrying its status: ok, store full, or exponent not descending; a zero
// coefficient is dropped with status ok, and a refused term leaves the store
// unchanged. cmd 2 adds: the back end walks both stores from the highest
// exponent down and returns the nonzero sum terms in descending exponent
// order, is_last set on the final one, or one transaction with no_terms set
// when the sum is empty; both stores are then empty again. cmd 3 is taken
// and returns nothing. A front end checks loads and writes the term RAMs,
// and a four-entry job queue decouples it from the back end, which owns the
// output register, so loads keep flowing while acknowledges wait on a
// stalled output. After the back end takes an add off the queue, it runs at
// most as many merge steps as both stores hold terms: every step is a
// registered read of the term RAMs followed by a compare-and-sum. From the
// accepted add until its last sum transaction is loaded into the output
// register, no new transaction is accepted. Each store holds MAX_TERMS
// terms; no clearing pass is needed after reset.
module sparse_polynomial_adder import spa_pkg::*; #(
  parameter int unsigned MAX_TERMS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              cmd_i,
  input  logic signed [COEF_W-1:0] coef_i,
  input  logic [EXP_W-1:0]        exponent_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [SUM_W-1:0] sum_coef_o,
  output logic [EXP_W-1:0]        sum_exp_o,
  output logic                    is_last_o,
  output logic                    no_terms_o,
  output logic [1:0]              status_o
);

`include "sparse_polynomial_adder_defines.svh"

  localparam int unsigned AW = $clog2(MAX_TERMS);
  localparam int unsigned CW = $clog2(MAX_TERMS + 1);
  localparam int unsigned JW = $bits(spa_job_t);

  // Front to queue
  logic     q_push, q_full, q_pop, q_empty;
  spa_job_t q_job_in, q_job_out;

  // Term store write side (front) and read side (back)
  logic              we_a, we_b;
  logic [AW-1:0]     waddr;
  logic [TERM_W-1:0] wdata;
  logic              rd_en;
  logic [AW-1:0]     raddr_a, raddr_b;
  logic [TERM_W-1:0] rdata_a, rdata_b;

  // Store fill counts, held until the merge reports done
  logic [CW-1:0] cnt_a, cnt_b;
  logic          add_done;

  spa_front #(
    .MAX_TERMS(MAX_TERMS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .coef_i     (coef_i),
    .exponent_i (exponent_i),
    .q_push_o   (q_push),
    .q_job_o    (q_job_in),
    .q_full_i   (q_full),
    .we_a_o     (we_a),
    .we_b_o     (we_b),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .cnt_a_o    (cnt_a),
    .cnt_b_o    (cnt_b),
    .add_done_i (add_done)
  );

  spa_fifo #(
    .WIDTH(JW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_job_out),
    .empty_o (q_empty)
  );

  spa_ram #(
    .WIDTH(TERM_W),
    .DEPTH(MAX_TERMS)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  spa_ram #(
    .WIDTH(TERM_W),
    .DEPTH(MAX_TERMS)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  spa_back #(
    .MAX_TERMS(MAX_TERMS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_job_i     (q_job_out),
    .q_pop_o     (q_pop),
    .cnt_a_i     (cnt_a),
    .cnt_b_i     (cnt_b),
    .rd_en_o     (rd_en),
    .raddr_a_o   (raddr_a),
    .raddr_b_o   (raddr_b),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b),
    .add_done_o  (add_done),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sum_coef_o  (sum_coef_o),
    .sum_exp_o   (sum_exp_o),
    .is_last_o   (is_last_o),
    .no_terms_o  (no_terms_o),
    .status_o    (status_o)
  );

  // Queue is never written while full.
  `SPA_ASSERT_HOLDS(a_no_push_full, clk_i, rst_ni, q_push, !q_full, "job pushed into full queue")

  // Nothing may be queued behind an add: the queue drains before it finishes.
  `SPA_ASSERT_HOLDS(a_done_queue_empty, clk_i, rst_ni, add_done, q_empty, "job queued behind add")

  // A store is written only below its capacity.
  `SPA_ASSERT_HOLDS(a_store_in_range, clk_i, rst_ni, we_a || we_b,
                    (we_a && (cnt_a < CW'(MAX_TERMS))) || (we_b && (cnt_b < CW'(MAX_TERMS))),
                    "term store written past capacity")

  // An empty-sum result is a single, final, zero transaction.
  `SPA_ASSERT_HOLDS(a_empty_sum_shape, clk_i, rst_ni, out_valid_o && no_terms_o,
                    is_last_o && (sum_coef_o == '0) && (status_o == ST_OK),
                    "malformed empty-sum result")

  // Once the merge is done the front end takes transactions again.
  `SPA_ASSERT_NEXT(a_resume_after_add, clk_i, rst_ni, add_done, !in_stall_o, "input still stalled after add")

endmodule
